@@ hdl/cpig_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpig_pkg: shared types and constants of the convex polygon GJK unit
// Widths, command codes, datapath operation codes and the command/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package cpig_pkg;

  localparam int MAX_VERTICES   = 16;
  localparam int MAX_ITERATIONS = 32;
  localparam int COORD_WIDTH    = 32;

  // Simplex points are exact differences, directions can be one more
  // difference away and then negated.
  localparam int PT_W   = COORD_WIDTH + 1;
  localparam int DIR_W  = COORD_WIDTH + 3;
  localparam int PROD_W = 2 * DIR_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

  localparam logic [1:0] CMD_ADD_A = 2'd0;
  localparam logic [1:0] CMD_ADD_B = 2'd1;
  localparam logic [1:0] CMD_RUN   = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  typedef enum logic [3:0] {
    OP_DOT_A,   // first-shape vertex . d
    OP_DOT_B,   // second-shape vertex . d
    OP_DOT_PD,  // support point . d
    OP_DOT_E,   // edge . (-l)
    OP_CRS_E,   // edge x (-l)
    OP_CRS_W,   // ab x ac
    OP_CRS_AC,  // ac x (-a)
    OP_DOT_AC,  // ac . (-a)
    OP_CRS_AB   // ab x (-a)
  } op_t;

  typedef struct packed {
    logic vtx_wr;
    logic vtx_sel;
    logic clr_cnt;
    logic rd_en;
    logic k_clr;
    logic k_inc;
    op_t  op;
    logic op_load;
    logic best_a_upd;
    logic best_b_upd;
    logic d_init;
    logic d_neg;
    logic p_set;
    logic sp_first;
    logic sp_push;
    logic esel;
    logic perp_neg;
    logic edge_keep;
    logic edge_drop;
    logic tri_ac;
  } dp_cmd_t;

  typedef struct packed {
    logic sum_pos;
    logic sum_neg;
    logic gt_best_a;
    logic lt_best_b;
    logic k_zero;
    logic k_last_a;
    logic k_last_b;
    logic a_empty;
    logic b_empty;
    logic size_two;
  } dp_sts_t;

endpackage

@@ hdl/convex_polygon_intersect_gjk_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_polygon_intersect_gjk_unit: 2D GJK overlap test of two polygons
// Loads up to 16 vertices per shape and, on a run beat, decides in Q16.16
// fixed point whether the two convex shapes overlap.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  command, vertex_x, vertex_y
//  out      out_valid/ out_stall intersect_res, timed_out
//
//  A support search visits every vertex of both shapes. A run seeds the simplex
//  with one support search, then per pass runs a support search, the support
//  test and the simplex case, and at last posts the result, all through one
//  shared product unit.
//  rst is synchronous; it empties both shapes and the result register.
//  in_stall is high while a run is in progress; the result waits in its
//  register while out_stall is high, and the unit takes beats meanwhile.
// ----------------------------------------------------------------------------
module convex_polygon_intersect_gjk_unit (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              command,
  input  logic signed [cpig_pkg::COORD_WIDTH-1:0] vertex_x,
  input  logic signed [cpig_pkg::COORD_WIDTH-1:0] vertex_y,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    intersect_res,
  output logic                                    timed_out
);

  cpig_pkg::dp_cmd_t dp_cmd;
  cpig_pkg::dp_sts_t dp_sts;

  cpig_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .intersect_res (intersect_res),
    .timed_out     (timed_out),
    .cmd           (dp_cmd),
    .sts           (dp_sts)
  );

  cpig_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (dp_cmd),
    .vertex_x (vertex_x),
    .vertex_y (vertex_y),
    .sts      (dp_sts)
  );

endmodule

@@ hdl/cpig_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpig_datapath: storage and arithmetic of the GJK unit
// Holds both vertex stores, the simplex, the search direction and a shared
// dot/cross product unit (operand register, two multipliers, adder).
// ----------------------------------------------------------------------------
module cpig_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cpig_pkg::dp_cmd_t                    cmd,
  input  logic signed [cpig_pkg::COORD_WIDTH-1:0] vertex_x,
  input  logic signed [cpig_pkg::COORD_WIDTH-1:0] vertex_y,
  output cpig_pkg::dp_sts_t                    sts
);

  localparam int CW = cpig_pkg::COORD_WIDTH;
  localparam int PW = cpig_pkg::PT_W;
  localparam int DW = cpig_pkg::DIR_W;
  localparam int RW = cpig_pkg::PROD_W;
  localparam int SW = cpig_pkg::SUM_W;
  localparam int NW = cpig_pkg::CNT_W;
  localparam int AW = cpig_pkg::ADDR_W;

  logic signed [CW-1:0] mem_ax [cpig_pkg::MAX_VERTICES];
  logic signed [CW-1:0] mem_ay [cpig_pkg::MAX_VERTICES];
  logic signed [CW-1:0] mem_bx [cpig_pkg::MAX_VERTICES];
  logic signed [CW-1:0] mem_by [cpig_pkg::MAX_VERTICES];
  logic signed [CW-1:0] ra_x, ra_y, rb_x, rb_y;
  logic signed [CW-1:0] best_ax, best_ay, best_bx, best_by;
  logic signed [SW-1:0] best_a, best_b;

  logic [NW-1:0] cnt_a, cnt_b, k;
  logic          full_a, full_b;

  logic signed [DW-1:0] d_x, d_y;
  logic signed [PW-1:0] p_x, p_y;
  logic signed [PW-1:0] sp_x [3];
  logic signed [PW-1:0] sp_y [3];
  logic [1:0]           size;

  logic signed [PW-1:0] l_x, l_y, r_x, r_y;
  logic signed [DW-1:0] e_x, e_y, nl_x, nl_y;
  logic signed [DW-1:0] ab_x, ab_y, ac_x, ac_y, na_x, na_y;

  logic signed [DW-1:0] u0, u1, v0, v1;
  logic signed [DW-1:0] u0_next, u1_next, v0_next, v1_next;
  logic                 sub, sub_next;
  logic signed [RW-1:0] prod0, prod1;
  logic signed [SW-1:0] sum;

  assign full_a = (cnt_a == NW'(cpig_pkg::MAX_VERTICES));
  assign full_b = (cnt_b == NW'(cpig_pkg::MAX_VERTICES));

  // Vertex stores.
  always_ff @(posedge clk) begin
    if (cmd.vtx_wr && !cmd.vtx_sel && !full_a) begin
      mem_ax[cnt_a[AW-1:0]] <= vertex_x;
      mem_ay[cnt_a[AW-1:0]] <= vertex_y;
    end
    if (cmd.vtx_wr && cmd.vtx_sel && !full_b) begin
      mem_bx[cnt_b[AW-1:0]] <= vertex_x;
      mem_by[cnt_b[AW-1:0]] <= vertex_y;
    end
    if (cmd.rd_en) begin
      ra_x <= mem_ax[k[AW-1:0]];
      ra_y <= mem_ay[k[AW-1:0]];
      rb_x <= mem_bx[k[AW-1:0]];
      rb_y <= mem_by[k[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a <= '0;
      cnt_b <= '0;
      k     <= '0;
    end else begin
      if (cmd.clr_cnt) begin
        cnt_a <= '0;
        cnt_b <= '0;
      end else if (cmd.vtx_wr && !cmd.vtx_sel && !full_a) begin
        cnt_a <= cnt_a + NW'(1);
      end else if (cmd.vtx_wr && cmd.vtx_sel && !full_b) begin
        cnt_b <= cnt_b + NW'(1);
      end
      if (cmd.k_clr) begin
        k <= '0;
      end else if (cmd.k_inc) begin
        k <= k + NW'(1);
      end
    end
  end

  // Geometry of the current simplex. The edge runs from the newer point l
  // toward the older point r.
  always_comb begin
    l_x  = cmd.esel ? sp_x[2] : sp_x[1];
    l_y  = cmd.esel ? sp_y[2] : sp_y[1];
    r_x  = cmd.esel ? sp_x[1] : sp_x[0];
    r_y  = cmd.esel ? sp_y[1] : sp_y[0];
    e_x  = DW'(r_x) - DW'(l_x);
    e_y  = DW'(r_y) - DW'(l_y);
    nl_x = -DW'(l_x);
    nl_y = -DW'(l_y);
    ab_x = DW'(sp_x[1]) - DW'(sp_x[2]);
    ab_y = DW'(sp_y[1]) - DW'(sp_y[2]);
    ac_x = DW'(sp_x[0]) - DW'(sp_x[2]);
    ac_y = DW'(sp_y[0]) - DW'(sp_y[2]);
    na_x = -DW'(sp_x[2]);
    na_y = -DW'(sp_y[2]);
  end

  // Operand select. A cross product u x v is u.x*v.y - u.y*v.x.
  always_comb begin
    u0_next  = '0;
    u1_next  = '0;
    v0_next  = '0;
    v1_next  = '0;
    sub_next = 1'b0;
    case (cmd.op)
      cpig_pkg::OP_DOT_A: begin
        u0_next = DW'(ra_x); v0_next = d_x; u1_next = DW'(ra_y); v1_next = d_y;
      end
      cpig_pkg::OP_DOT_B: begin
        u0_next = DW'(rb_x); v0_next = d_x; u1_next = DW'(rb_y); v1_next = d_y;
      end
      cpig_pkg::OP_DOT_PD: begin
        u0_next = DW'(p_x); v0_next = d_x; u1_next = DW'(p_y); v1_next = d_y;
      end
      cpig_pkg::OP_DOT_E: begin
        u0_next = e_x; v0_next = nl_x; u1_next = e_y; v1_next = nl_y;
      end
      cpig_pkg::OP_CRS_E: begin
        u0_next = e_x; v0_next = nl_y; u1_next = e_y; v1_next = nl_x;
        sub_next = 1'b1;
      end
      cpig_pkg::OP_CRS_W: begin
        u0_next = ab_x; v0_next = ac_y; u1_next = ab_y; v1_next = ac_x;
        sub_next = 1'b1;
      end
      cpig_pkg::OP_CRS_AC: begin
        u0_next = ac_x; v0_next = na_y; u1_next = ac_y; v1_next = na_x;
        sub_next = 1'b1;
      end
      cpig_pkg::OP_DOT_AC: begin
        u0_next = ac_x; v0_next = na_x; u1_next = ac_y; v1_next = na_y;
      end
      cpig_pkg::OP_CRS_AB: begin
        u0_next = ab_x; v0_next = na_y; u1_next = ab_y; v1_next = na_x;
        sub_next = 1'b1;
      end
      default: begin
        sub_next = 1'b0;
      end
    endcase
  end

  // Product unit: operands, then products, then sum, one register each.
  always_ff @(posedge clk) begin
    if (cmd.op_load) begin
      u0  <= u0_next;
      u1  <= u1_next;
      v0  <= v0_next;
      v1  <= v1_next;
      sub <= sub_next;
    end
    prod0 <= u0 * v0;
    prod1 <= u1 * v1;
    sum   <= sub ? (SW'(prod0) - SW'(prod1)) : (SW'(prod0) + SW'(prod1));
  end

  // Support search bookkeeping, direction and simplex updates.
  always_ff @(posedge clk) begin
    if (cmd.best_a_upd) begin
      best_a  <= sum;
      best_ax <= ra_x;
      best_ay <= ra_y;
    end
    if (cmd.best_b_upd) begin
      best_b  <= sum;
      best_bx <= rb_x;
      best_by <= rb_y;
    end
    if (cmd.p_set) begin
      p_x <= PW'(best_ax) - PW'(best_bx);
      p_y <= PW'(best_ay) - PW'(best_by);
    end
    if (cmd.d_init) begin
      d_x <= DW'(ra_x);
      d_y <= DW'(ra_y);
    end else if (cmd.d_neg) begin
      d_x <= -d_x;
      d_y <= -d_y;
    end else if (cmd.edge_keep) begin
      d_x <= cmd.perp_neg ? e_y : -e_y;
      d_y <= cmd.perp_neg ? -e_x : e_x;
    end else if (cmd.edge_drop) begin
      d_x <= nl_x;
      d_y <= nl_y;
    end else if (cmd.tri_ac) begin
      d_x <= cmd.perp_neg ? ac_y : -ac_y;
      d_y <= cmd.perp_neg ? -ac_x : ac_x;
    end
    if (cmd.sp_first) begin
      sp_x[0] <= p_x;
      sp_y[0] <= p_y;
    end else if (cmd.sp_push) begin
      sp_x[size] <= p_x;
      sp_y[size] <= p_y;
    end else if (cmd.edge_keep) begin
      sp_x[0] <= r_x;
      sp_y[0] <= r_y;
      sp_x[1] <= l_x;
      sp_y[1] <= l_y;
    end else if (cmd.edge_drop) begin
      sp_x[0] <= l_x;
      sp_y[0] <= l_y;
    end else if (cmd.tri_ac) begin
      sp_x[1] <= sp_x[2];
      sp_y[1] <= sp_y[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= '0;
    end else if (cmd.sp_first || cmd.edge_drop) begin
      size <= 2'd1;
    end else if (cmd.sp_push) begin
      size <= size + 2'd1;
    end else if (cmd.edge_keep || cmd.tri_ac) begin
      size <= 2'd2;
    end
  end

  always_comb begin
    sts.sum_pos   = !sum[SW-1] && (sum != '0);
    sts.sum_neg   = sum[SW-1];
    sts.gt_best_a = (sum > best_a);
    sts.lt_best_b = (sum < best_b);
    sts.k_zero    = (k == '0);
    sts.k_last_a  = ((k + NW'(1)) == cnt_a);
    sts.k_last_b  = ((k + NW'(1)) == cnt_b);
    sts.a_empty   = (cnt_a == '0);
    sts.b_empty   = (cnt_b == '0);
    sts.size_two  = (size == 2'd2);
  end

endmodule

@@ hdl/cpig_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpig_ctrl: sequencer of the GJK unit
// Takes input beats, steps the datapath through support searches and simplex
// cases, counts passes and holds the result register.
// ----------------------------------------------------------------------------
module cpig_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               intersect_res,
  output logic               timed_out,
  output cpig_pkg::dp_cmd_t  cmd,
  input  cpig_pkg::dp_sts_t  sts
);

  localparam int IW = cpig_pkg::ITER_W;

  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT_RD, ST_INIT_D,
    ST_SUP_A_RD, ST_SUP_A_LD, ST_SUP_A_CMP,
    ST_SUP_B_RD, ST_SUP_B_LD, ST_SUP_B_CMP,
    ST_SUP_P, ST_INIT_DONE, ST_LOOP_CHK, ST_PD_LD, ST_PD_CHK, ST_STEP,
    ST_E_LD, ST_E_DOT, ST_E_CRS,
    ST_T_W_LD, ST_T_W, ST_T_AC, ST_T_ACD, ST_T_AB,
    ST_W1, ST_W2, ST_DONE
  } state_t;

  state_t        state, ret, sret;
  logic          esel, wpos, wneg, acneg;
  logic [IW-1:0] iter;
  logic          hit, tmo;
  logic          same_w, oppo_w;

  assign in_stall = (state != ST_IDLE);
  assign same_w   = (wpos && sts.sum_pos) || (wneg && sts.sum_neg);
  assign oppo_w   = (wpos && sts.sum_neg) || (wneg && sts.sum_pos);

  always_comb begin
    cmd          = '0;
    cmd.op       = cpig_pkg::OP_DOT_A;
    cmd.esel     = esel;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (command)
            cpig_pkg::CMD_ADD_A: cmd.vtx_wr = 1'b1;
            cpig_pkg::CMD_ADD_B: begin
              cmd.vtx_wr  = 1'b1;
              cmd.vtx_sel = 1'b1;
            end
            cpig_pkg::CMD_CLEAR: cmd.clr_cnt = 1'b1;
            default: cmd.k_clr = 1'b1;
          endcase
        end
      end
      ST_INIT_RD: cmd.rd_en = 1'b1;
      ST_INIT_D: cmd.d_init = 1'b1;
      ST_SUP_A_RD, ST_SUP_B_RD: cmd.rd_en = 1'b1;
      ST_SUP_A_LD: cmd.op_load = 1'b1;
      ST_SUP_B_LD: begin
        cmd.op      = cpig_pkg::OP_DOT_B;
        cmd.op_load = 1'b1;
      end
      ST_SUP_A_CMP: begin
        cmd.best_a_upd = sts.k_zero || sts.gt_best_a;
        cmd.k_clr      = sts.k_last_a;
        cmd.k_inc      = !sts.k_last_a;
      end
      ST_SUP_B_CMP: begin
        cmd.best_b_upd = sts.k_zero || sts.lt_best_b;
        cmd.k_clr      = sts.k_last_b;
        cmd.k_inc      = !sts.k_last_b;
      end
      ST_SUP_P: cmd.p_set = 1'b1;
      ST_INIT_DONE: begin
        cmd.sp_first = 1'b1;
        cmd.d_neg    = 1'b1;
      end
      ST_LOOP_CHK: cmd.k_clr = 1'b1;
      ST_PD_LD: begin
        cmd.op      = cpig_pkg::OP_DOT_PD;
        cmd.op_load = 1'b1;
      end
      ST_PD_CHK: cmd.sp_push = sts.sum_pos;
      ST_E_LD: begin
        cmd.op      = cpig_pkg::OP_DOT_E;
        cmd.op_load = 1'b1;
      end
      ST_E_DOT: begin
        cmd.op        = cpig_pkg::OP_CRS_E;
        cmd.op_load   = sts.sum_pos;
        cmd.edge_drop = !sts.sum_pos;
      end
      ST_E_CRS: begin
        cmd.edge_keep = 1'b1;
        cmd.perp_neg  = sts.sum_neg;
      end
      ST_T_W_LD: begin
        cmd.op      = cpig_pkg::OP_CRS_W;
        cmd.op_load = 1'b1;
      end
      ST_T_W: begin
        cmd.op      = cpig_pkg::OP_CRS_AC;
        cmd.op_load = 1'b1;
      end
      ST_T_AC: begin
        cmd.op      = same_w ? cpig_pkg::OP_DOT_AC : cpig_pkg::OP_CRS_AB;
        cmd.op_load = 1'b1;
      end
      ST_T_ACD: begin
        cmd.tri_ac   = sts.sum_pos;
        cmd.perp_neg = acneg;
      end
      default: cmd.op_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ret           <= ST_IDLE;
      sret          <= ST_IDLE;
      esel          <= 1'b0;
      wpos          <= 1'b0;
      wneg          <= 1'b0;
      acneg         <= 1'b0;
      iter          <= '0;
      hit           <= 1'b0;
      tmo           <= 1'b0;
      out_valid     <= 1'b0;
      intersect_res <= 1'b0;
      timed_out     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid && command == cpig_pkg::CMD_RUN) begin
            hit <= 1'b0;
            tmo <= 1'b0;
            if (sts.a_empty || sts.b_empty) begin
              state <= ST_DONE;
            end else begin
              state <= ST_INIT_RD;
            end
          end
        end
        ST_INIT_RD: state <= ST_INIT_D;
        ST_INIT_D: begin
          sret  <= ST_INIT_DONE;
          state <= ST_SUP_A_RD;
        end
        ST_SUP_A_RD: state <= ST_SUP_A_LD;
        ST_SUP_A_LD: begin
          ret   <= ST_SUP_A_CMP;
          state <= ST_W1;
        end
        ST_SUP_A_CMP: state <= sts.k_last_a ? ST_SUP_B_RD : ST_SUP_A_RD;
        ST_SUP_B_RD: state <= ST_SUP_B_LD;
        ST_SUP_B_LD: begin
          ret   <= ST_SUP_B_CMP;
          state <= ST_W1;
        end
        ST_SUP_B_CMP: state <= sts.k_last_b ? ST_SUP_P : ST_SUP_B_RD;
        ST_SUP_P: state <= sret;
        ST_INIT_DONE: begin
          iter  <= '0;
          state <= ST_LOOP_CHK;
        end
        ST_LOOP_CHK: begin
          if (iter == IW'(cpig_pkg::MAX_ITERATIONS)) begin
            tmo   <= 1'b1;
            state <= ST_DONE;
          end else begin
            iter  <= iter + IW'(1);
            sret  <= ST_PD_LD;
            state <= ST_SUP_A_RD;
          end
        end
        ST_PD_LD: begin
          ret   <= ST_PD_CHK;
          state <= ST_W1;
        end
        ST_PD_CHK: state <= sts.sum_pos ? ST_STEP : ST_DONE;
        ST_STEP: begin
          // The simplex now holds two or three points.
          if (sts.size_two) begin
            esel  <= 1'b0;
            state <= ST_E_LD;
          end else begin
            state <= ST_T_W_LD;
          end
        end
        ST_E_LD: begin
          ret   <= ST_E_DOT;
          state <= ST_W1;
        end
        ST_E_DOT: begin
          if (sts.sum_pos) begin
            ret   <= ST_E_CRS;
            state <= ST_W1;
          end else begin
            state <= ST_LOOP_CHK;
          end
        end
        ST_E_CRS: state <= ST_LOOP_CHK;
        ST_T_W_LD: begin
          ret   <= ST_T_W;
          state <= ST_W1;
        end
        ST_T_W: begin
          wpos  <= sts.sum_pos;
          wneg  <= sts.sum_neg;
          ret   <= ST_T_AC;
          state <= ST_W1;
        end
        ST_T_AC: begin
          acneg <= sts.sum_neg;
          ret   <= same_w ? ST_T_ACD : ST_T_AB;
          state <= ST_W1;
        end
        ST_T_ACD: begin
          if (sts.sum_pos) begin
            state <= ST_LOOP_CHK;
          end else begin
            esel  <= 1'b1;
            state <= ST_E_LD;
          end
        end
        ST_T_AB: begin
          if (oppo_w) begin
            esel  <= 1'b1;
            state <= ST_E_LD;
          end else begin
            hit   <= 1'b1;
            state <= ST_DONE;
          end
        end
        ST_W1: state <= ST_W2;
        ST_W2: state <= ret;
        ST_DONE: begin
          if (!out_valid) begin
            out_valid     <= 1'b1;
            intersect_res <= hit;
            timed_out     <= tmo;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
